>>> rtl/core/wrm_pkg.sv
// wrm_pkg: shared constants for the wildcard regex matcher.
// Opcodes, special pattern bytes, field widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package wrm_pkg;

   localparam int MAX_PATTERN_DEF = 64;

   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 6;
   localparam int SYMBOL_W = 8;
   localparam int LENGTH_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TEXT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

   localparam logic [SYMBOL_W-1:0] SYM_ANY  = 8'h2E;
   localparam logic [SYMBOL_W-1:0] SYM_STAR = 8'h2A;

   // register index, taken from paddr[2]
   localparam logic REG_PATTERN_LENGTH = 1'b0;

endpackage

>>> rtl/core/wrm_if.sv
// wrm_if: valid/ready channel interfaces for request and response beats.
// Depends on wrm_pkg for field widths.
`timescale 1ns / 1ps

interface wrm_req_if;
   logic                           valid;
   logic                           ready;
   logic [wrm_pkg::OPCODE_W-1:0]   opcode;
   logic [wrm_pkg::INDEX_W-1:0]    pattern_index;
   logic [wrm_pkg::SYMBOL_W-1:0]   symbol;

   modport source (output valid, output opcode, output pattern_index, output symbol,
                   input ready);
   modport sink   (input valid, input opcode, input pattern_index, input symbol,
                   output ready);
endinterface

interface wrm_rsp_if;
   logic valid;
   logic ready;
   logic full_match;

   modport source (output valid, output full_match, input ready);
   modport sink   (input valid, input full_match, output ready);
endinterface

>>> rtl/core/wrm_csr.sv
// wrm_csr: APB-style register block holding pattern_length.
// Depends on wrm_pkg.
`timescale 1ns / 1ps

module wrm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wrm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [wrm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [wrm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [wrm_pkg::LENGTH_W-1:0]     pattern_length
);
   import wrm_pkg::*;

   logic [LENGTH_W-1:0] length_ff;
   logic [LENGTH_W-1:0] length_in;
   logic                wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_PATTERN_LENGTH);

   always_comb begin
      length_in = length_ff;
      if (wr_hit) begin
         length_in = pwdata[LENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PATTERN_LENGTH) begin
         prdata = {{(CSR_DATA_W-LENGTH_W){1'b0}}, length_ff};
      end
   end

   assign pattern_length = length_ff;

endmodule

>>> rtl/core/wrm_engine.sv
// wrm_engine: pattern store and match-row memories plus the walk sequencer
// that updates the row one pattern position per cycle. Depends on wrm_pkg, wrm_if.
`timescale 1ns / 1ps

module wrm_engine #(
   parameter int MaxPattern = wrm_pkg::MAX_PATTERN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [wrm_pkg::LENGTH_W-1:0] pattern_length,
   wrm_req_if.sink                      req,
   wrm_rsp_if.source                    rsp
);
   import wrm_pkg::*;

   localparam int AW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
   localparam int JW = $clog2(MaxPattern + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   // memories: pattern bytes and row bits 1..MaxPattern (entry j-1 holds bit j)
   logic [SYMBOL_W-1:0] pattern_ram [MaxPattern];
   logic                row_ram     [MaxPattern];

   logic                state_ff, state_in;
   logic [JW-1:0]       pos_ff, pos_in;
   logic                start_ff, start_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                row0_ff, row0_in;
   logic                row_clear_ff, row_clear_in;
   logic                old_prev_ff, old_prev_in;
   logic                new_p1_ff, new_p1_in;
   logic                new_p2_ff, new_p2_in;
   logic [SYMBOL_W-1:0] pat_prev_ff, pat_prev_in;
   logic                result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SYMBOL_W-1:0] pat_rdata_ff;
   logic                row_rdata_ff;

   logic [JW-1:0]       eff_len;
   logic [JW-1:0]       pos_m1;
   logic [AW-1:0]       rd_addr;
   logic                req_fire;
   logic                pat_we;
   logic                row_we;
   logic                old_cur;
   logic                fits_cur;
   logic                fits_prev;
   logic                is_star;
   logic                first_pos;
   logic                last_pos;
   logic                new_bit;

   assign eff_len = (int'(pattern_length) > MaxPattern) ? JW'(MaxPattern)
                                                       : JW'(pattern_length);

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;

   assign pos_m1    = pos_ff - JW'(1);
   assign last_pos  = (pos_ff == JW'(MaxPattern));
   assign first_pos = (pos_ff == JW'(1));
   assign rd_addr   = (state_ff == ST_WALK && !last_pos) ? pos_ff[AW-1:0] : '0;

   assign pat_we = req_fire && (req.opcode == OP_LOAD)
                   && (int'(req.pattern_index) < MaxPattern);
   assign row_we = (state_ff == ST_WALK);

   // row reads as zero until the first walk after reset has rewritten it
   assign old_cur   = row_clear_ff ? 1'b0 : row_rdata_ff;
   assign is_star   = (pat_rdata_ff == SYM_STAR);
   assign fits_cur  = (pat_rdata_ff == SYM_ANY) || (pat_rdata_ff == sym_ff);
   assign fits_prev = (pat_prev_ff == SYM_ANY) || (pat_prev_ff == sym_ff);

   always_comb begin
      new_bit = 1'b0;
      if (pos_ff <= eff_len) begin
         if (start_ff) begin
            new_bit = is_star && !first_pos && new_p2_ff;
         end else if (fits_cur) begin
            new_bit = old_prev_ff;
         end else if (is_star && !first_pos) begin
            new_bit = new_p2_ff || (fits_prev && old_cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pattern_ram[AW'(req.pattern_index)] <= req.symbol;
      end
      pat_rdata_ff <= pattern_ram[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_ram[pos_m1[AW-1:0]] <= new_bit;
      end
      row_rdata_ff <= row_ram[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      sym_in       = sym_ff;
      row0_in      = row0_ff;
      row_clear_in = row_clear_ff;
      old_prev_in  = old_prev_ff;
      new_p1_in    = new_p1_ff;
      new_p2_in    = new_p2_ff;
      pat_prev_in  = pat_prev_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         case (req.opcode)
            OP_START, OP_TEXT: begin
               start_in    = (req.opcode == OP_START);
               state_in    = ST_WALK;
               pos_in      = JW'(1);
               sym_in      = req.symbol;
               old_prev_in = row0_ff;
               row0_in     = (req.opcode == OP_START);
               new_p1_in   = (req.opcode == OP_START);
               result_in   = (req.opcode == OP_START);
            end
            default: begin
               result_in    = 1'b0;
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      if (state_ff == ST_WALK) begin
         old_prev_in = old_cur;
         new_p2_in   = new_p1_ff;
         new_p1_in   = new_bit;
         pat_prev_in = pat_rdata_ff;
         pos_in      = pos_ff + JW'(1);
         if (pos_ff == eff_len) begin
            result_in = new_bit;
         end
         if (last_pos) begin
            state_in     = ST_IDLE;
            row_clear_in = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row0_ff      <= 1'b1;
         row_clear_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row0_ff      <= row0_in;
         row_clear_ff <= row_clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      start_ff    <= start_in;
      sym_ff      <= sym_in;
      old_prev_ff <= old_prev_in;
      new_p1_ff   <= new_p1_in;
      new_p2_ff   <= new_p2_in;
      pat_prev_ff <= pat_prev_in;
      result_ff   <= result_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.full_match = result_ff;

endmodule

>>> rtl/core/wildcard_regex_matcher.sv
// Wildcard regex matcher: '.' matches any byte, '*' repeats the element before it.
// Load beats write pattern bytes by index; a start beat builds the empty-text row; each
// text beat advances the match row and returns whether the whole pattern (first
// pattern_length bytes, capped at MAX_PATTERN) matches all text since the last start.
// Load and unused-opcode beats return 0 in the next cycle. A start or text beat keeps the
// engine busy after it is accepted, walking one pattern position per cycle over the row
// memory up to position MAX_PATTERN. Its result is presented in the next cycle, and the next
// beat can be accepted in that same cycle if the result is taken then. Result is held in an
// output register until taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module wildcard_regex_matcher #(
   parameter int MAX_PATTERN = wrm_pkg::MAX_PATTERN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   wrm_req_if.sink                          req_bus,
   wrm_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wrm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [wrm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [wrm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import wrm_pkg::*;

   logic [LENGTH_W-1:0] pattern_length;

   wrm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .pattern_length (pattern_length)
   );

   wrm_engine #(
      .MaxPattern (MAX_PATTERN)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .pattern_length (pattern_length),
      .req            (req_bus),
      .rsp            (rsp_bus)
   );

endmodule

>>> rtl/core/wrm_checker.sv
// wrm_checker: port-level assertions for the wildcard regex matcher, bound to the top.
// Depends on wrm_pkg.
`timescale 1ns / 1ps

module wrm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [wrm_pkg::OPCODE_W-1:0]   req_opcode,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_full_match
);
   import wrm_pkg::*;

   // result beat holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped before accept");

   // a pending result blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result pending");

   // load and unused-opcode beats answer 0 in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_LOAD || req_opcode == OP_NONE)
      |=> rsp_valid && !rsp_full_match)
      else $error("load or unused beat gave wrong result");

   // a start or text beat cannot complete in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_START || req_opcode == OP_TEXT)
      |=> !rsp_valid && !req_ready)
      else $error("walk finished too early");

endmodule

bind wildcard_regex_matcher wrm_checker u_wrm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_opcode     (req_bus.opcode),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_full_match (rsp_bus.full_match)
);

>>> bench/wrm_match_checker.sv
// wrm_match_checker: watches the request, result and register ports of the regex matcher,
// predicts full_match for every request beat and compares it with the result beats.
// Depends on wrm_pkg and the channel interfaces in wrm_if.
`timescale 1ns / 1ps

module wrm_match_checker
   import wrm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   wrm_req_if                     req_mon,
   wrm_rsp_if                     rsp_mon,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   input  logic [CSR_DATA_W-1:0]  prdata,
   input  logic                   pready,
   output int unsigned            mismatch_count,
   output int unsigned            verdicts_owed
);

   logic [SYMBOL_W-1:0]      pattern_mem [MAX_PATTERN_DEF];
   logic [MAX_PATTERN_DEF:0] row_bits;
   logic [LENGTH_W-1:0]      length_reg;
   logic                     owed_match [$];
   int unsigned              fail_tally = 0;
   int unsigned              owed_tally = 0;
   int unsigned              rsp_seen = 0;

   assign mismatch_count = fail_tally;
   assign verdicts_owed  = owed_tally;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_tally++;
   endtask

   function automatic logic symbol_fits(input logic [SYMBOL_W-1:0] pat,
                                        input logic [SYMBOL_W-1:0] sym);
      return (pat == SYM_ANY) || (pat == sym);
   endfunction

   // Applies one request beat to the row and returns the match bit it reports.
   function automatic logic advance_row(input logic [OPCODE_W-1:0] op,
                                        input logic [INDEX_W-1:0]  idx,
                                        input logic [SYMBOL_W-1:0] sym);
      logic [MAX_PATTERN_DEF:0] next_bits;
      int unsigned              m;
      m = (length_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(length_reg);
      next_bits = '0;
      case (op)
         OP_LOAD: begin
            pattern_mem[idx] = sym;
            return 1'b0;
         end
         OP_START: begin
            next_bits[0] = 1'b1;
            // a star at position zero has nothing to repeat, so j starts at 2
            for (int j = 2; j <= m; j++)
               if (pattern_mem[j-1] == SYM_STAR) next_bits[j] = next_bits[j-2];
         end
         OP_TEXT: begin
            for (int j = 1; j <= m; j++) begin
               // equality wins over the star rule, so a literal '*' matches a '*'
               if (symbol_fits(pattern_mem[j-1], sym))
                  next_bits[j] = row_bits[j-1];
               else if (pattern_mem[j-1] == SYM_STAR && j >= 2)
                  next_bits[j] = next_bits[j-2] |
                                 (symbol_fits(pattern_mem[j-2], sym) & row_bits[j]);
            end
         end
         default: return 1'b0;
      endcase
      row_bits = next_bits;
      return row_bits[m];
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         row_bits    = '0;
         row_bits[0] = 1'b1;
         length_reg  = '0;
         owed_match.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_PATTERN_LENGTH) length_reg = pwdata[LENGTH_W-1:0];
            end else if (prdata !== CSR_DATA_W'(length_reg)) begin
               report_mismatch($sformatf("pattern_length read %0h, expected %0h",
                                         prdata, length_reg));
            end
         end
         if (req_mon.valid && req_mon.ready)
            owed_match.push_back(advance_row(req_mon.opcode, req_mon.pattern_index,
                                             req_mon.symbol));
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_seen++;
            if (owed_match.size() == 0) begin
               report_mismatch($sformatf("result beat %0d arrived with nothing owed", rsp_seen));
            end else begin
               want = owed_match.pop_front();
               if (rsp_mon.full_match !== want)
                  report_mismatch($sformatf("result beat %0d: full_match %b, expected %b",
                                            rsp_seen, rsp_mon.full_match, want));
            end
         end
      end
      owed_tally = owed_match.size();
   end

endmodule

>>> bench/tb_wildcard_regex_matcher.sv
// tb_wildcard_regex_matcher: stimulus and verdict for the wildcard regex matcher.
// Drives load/start/text beats with random gaps and stalls; wrm_match_checker does the checking.
// Depends on wrm_pkg, wrm_if, wildcard_regex_matcher and wrm_match_checker.
`timescale 1ns / 1ps

module tb_wildcard_regex_matcher;
   import wrm_pkg::*;

   localparam int unsigned RANDOM_BEATS  = 400;
   localparam int unsigned CYCLE_LIMIT   = 900000;
   localparam int unsigned SETTLE_CYCLES = MAX_PATTERN_DEF + 16;
   localparam logic [CSR_ADDR_W-1:0] LENGTH_ADDR = {REG_PATTERN_LENGTH, 2'b00};
   localparam logic [SYMBOL_W-1:0] CH_A = 8'h61;
   localparam logic [SYMBOL_W-1:0] CH_B = 8'h62;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   int unsigned mismatch_count, verdicts_owed;
   int unsigned cycle_count = 0;
   int unsigned beats_sent = 0;
   int unsigned cur_len = 0;
   bit calm = 1'b0;

   // what has been loaded, so no start or text beat reads an unwritten entry
   logic [SYMBOL_W-1:0] shadow_pat [MAX_PATTERN_DEF];
   bit                  written_map [MAX_PATTERN_DEF];
   logic [SYMBOL_W-1:0] text_beats [$];

   wrm_req_if req_bus();
   wrm_rsp_if rsp_bus();

   wildcard_regex_matcher DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   wrm_match_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .verdicts_owed  (verdicts_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 90);
   endfunction

   function automatic logic [SYMBOL_W-1:0] alpha_byte();
      return CH_A + SYMBOL_W'($urandom_range(0, 2));
   endfunction

   function automatic logic [SYMBOL_W-1:0] pattern_byte(input int unsigned i);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return SYMBOL_W'($urandom_range(0, 255));
      if (r < 28 && i > 0 && shadow_pat[i-1] != SYM_STAR) return SYM_STAR;
      if (r < 43) return SYM_ANY;
      return alpha_byte();
   endfunction

   function automatic int unsigned written_prefix();
      int unsigned n;
      n = 0;
      while (n < MAX_PATTERN_DEF && written_map[n]) n++;
      return n;
   endfunction

   // Random bytes, or text the pattern accepts, walked per element and sometimes spoiled.
   function automatic void fill_text(input int unsigned m);
      int unsigned j, reps, r;
      bit          star_next;
      text_beats.delete();
      r = $urandom_range(0, 99);
      if (r < 12 || m == 0) begin
         repeat ($urandom_range(1, 6)) text_beats.push_back(SYMBOL_W'($urandom_range(0, 255)));
         return;
      end
      j = 0;
      while (j < m) begin
         star_next = (j + 1 < m) && (shadow_pat[j+1] == SYM_STAR);
         if (shadow_pat[j] != SYM_STAR) begin
            reps = star_next ? $urandom_range(0, 3) : 1;
            repeat (reps)
               text_beats.push_back((shadow_pat[j] == SYM_ANY) ? alpha_byte() : shadow_pat[j]);
         end
         j += star_next ? 2 : 1;
      end
      if (r < 40 && text_beats.size() > 0)
         text_beats[$urandom_range(0, text_beats.size() - 1)] = alpha_byte();
      else if (r < 50)
         text_beats.push_back(alpha_byte());
   endfunction

   // valid is only lowered ahead of a gap, so back-to-back beats keep it high
   task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [SYMBOL_W-1:0] sym);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.pattern_index <= idx;
      req_bus.symbol        <= sym;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   task automatic load_byte(input int unsigned idx, input logic [SYMBOL_W-1:0] sym);
      send_beat(OP_LOAD, INDEX_W'(idx), sym);
      shadow_pat[idx]  = sym;
      written_map[idx] = 1'b1;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
   endtask

   // leaves psel high so that a following access needs no second assignment in one step
   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= LENGTH_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic set_length(input int unsigned len);
      logic [CSR_DATA_W-1:0] word;
      drain();
      word = CSR_DATA_W'(len);
      if ($urandom_range(0, 1) != 0) word[CSR_DATA_W-1:LENGTH_W] = $urandom;
      csr_access(1'b1, word);
      csr_access(1'b0, CSR_DATA_W'($urandom));
      psel    <= 1'b0;
      penable <= 1'b0;
      cur_len = len;
   endtask

   task automatic run_text();
      int unsigned r, room, m;
      m = (cur_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : cur_len;
      fill_text(m);
      foreach (text_beats[k]) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_beat(OP_NONE, INDEX_W'($urandom), SYMBOL_W'($urandom));
         end else if (r < 7) begin
            // length changes while the row is mid-text
            room = written_prefix();
            set_length((room == MAX_PATTERN_DEF) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, room));
            m = (cur_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : cur_len;
         end else if (r < 9 && m > 0) begin
            room = $urandom_range(0, m - 1);
            load_byte(room, pattern_byte(room));
         end
         send_beat(OP_TEXT, INDEX_W'($urandom), text_beats[k]);
      end
   endtask

   task automatic run_sequence(input int forced_len);
      int unsigned len, m, r, idx;
      bit          descending;
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (forced_len >= 0) len = forced_len;
      else if (r < 5)      len = 0;
      else if (r < 66)     len = $urandom_range(1, 8);
      else if (r < 92)     len = $urandom_range(9, 20);
      else if (r < 96)     len = MAX_PATTERN_DEF;
      else                 len = $urandom_range(MAX_PATTERN_DEF + 1, 127);
      m = (len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len;
      descending = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < m; k++) begin
         idx = descending ? m - 1 - k : k;
         if (m <= 20 || !written_map[idx] || $urandom_range(0, 15) == 0)
            load_byte(idx, pattern_byte(idx));
      end
      set_length(len);
      repeat ((m > 20) ? 1 : $urandom_range(1, 3)) begin
         // now and then keep going on the current row without a start
         if ($urandom_range(0, 4) != 0)
            send_beat(OP_START, INDEX_W'($urandom), SYMBOL_W'($urandom));
         run_text();
      end
   endtask

   // result side: bursts of ready with stalls of random length
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_NONE;
      req_bus.pattern_index = '0;
      req_bus.symbol        = '0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      foreach (written_map[i]) written_map[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pattern: text on the reset row, then a start and an unused-opcode beat
      set_length(0);
      send_beat(OP_TEXT, '0, 8'h00);
      send_beat(OP_START, '0, 8'h00);
      send_beat(OP_NONE, 6'h3F, 8'hFF);

      // star at position zero; a literal '*' in the text hits it by equality
      load_byte(0, SYM_STAR);
      load_byte(1, CH_A);
      set_length(2);
      send_beat(OP_START, 6'h2A, 8'h55);
      send_beat(OP_TEXT, 6'h15, SYM_STAR);
      send_beat(OP_TEXT, 6'h3F, CH_A);

      // "a*.*" plus the store edges
      load_byte(0, CH_A);
      load_byte(1, SYM_STAR);
      load_byte(2, SYM_ANY);
      load_byte(3, SYM_STAR);
      load_byte(63, 8'hFF);
      load_byte(62, 8'h00);
      set_length(4);
      send_beat(OP_START, '0, 8'hFF);
      send_beat(OP_TEXT, '0, CH_B);
      send_beat(OP_TEXT, '0, 8'hFF);
      set_length(2);
      send_beat(OP_TEXT, '0, CH_A);

      beats_sent = 0;
      run_sequence(127);
      while (beats_sent < RANDOM_BEATS) run_sequence(-1);
      calm = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/wrm_pkg.sv
rtl/core/wrm_if.sv
rtl/core/wrm_csr.sv
rtl/core/wrm_engine.sv
rtl/core/wildcard_regex_matcher.sv
rtl/core/wrm_checker.sv
bench/wrm_match_checker.sv
bench/tb_wildcard_regex_matcher.sv
